FILE: src/dss_pkg.sv
// Shared types and codes for the data set statistics block.
package dss_pkg;

  typedef enum logic [1:0] {
    K_WRITE = 2'd0,
    K_COUNT = 2'd1,
    K_SUM   = 2'd2,
    K_NONE  = 2'd3
  } kind_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_KADDR = 6'b000100,
    S_KLOAD = 6'b001000,
    S_CNT   = 6'b010000,
    S_DIV   = 6'b100000
  } state_t;

  localparam int DivSteps = 44;

endpackage

FILE: src/data_set_statistics_core.sv
// Top level of the data set statistics block: store, sequencer and divider.
//  channel | direction | handshake          | payload
//  in      | to block  | in_valid/in_stall  | kind, index, value
//  out     | from      | out_valid/out_stall| max..bad_index
//  cfg     | to block  | APB psel/penable   | n_entries at address 0
// With n used entries, a write shows its result in the cycle after acceptance. A count
// query sweeps the store once; a summary sweeps it once for max, min and total, once
// per entry for the mode, then runs the divider: one store read per cycle on each sweep.
// Reset is synchronous and clears control state; the store is not cleared.
// A new word is taken only when the sequencer is idle and no result waits.
module data_set_statistics_core import dss_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [7:0]         index,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] max_value,
  output logic [8:0]         max_count,
  output logic signed [31:0] min_value,
  output logic [8:0]         min_count,
  output logic [31:0]        value_range,
  output logic signed [39:0] total,
  output logic signed [35:0] mean_q4,
  output logic signed [31:0] mode_value,
  output logic [8:0]         mode_count,
  output logic [8:0]         match_count,
  output logic               bad_index,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = (AW > 9) ? AW : 9;

  state_t            state;
  kind_t             kind_r;
  logic [8:0]        n_entries;
  logic [8:0]        n0;
  logic [8:0]        n_used;
  logic [CW-1:0]     n_ext;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     oi;
  logic              pend;
  logic              first;
  logic [8:0]        c;
  logic [8:0]        c_fin;
  logic signed [31:0] key;
  logic [AW-1:0]     raddr;
  logic [31:0]       rdata;
  logic signed [31:0] rd_s;
  logic              we;
  logic              accept;
  logic              neg;
  logic [43:0]       dq;
  logic [9:0]        rem;
  logic [9:0]        rem_s;
  logic              qbit;
  logic [5:0]        dcnt;
  logic [39:0]       mag;
  logic [43:0]       q_fin;
  logic [43:0]       q_sgn;

  assign pready = 1'b1;
  assign prdata = {23'b0, n_entries};

  always_ff @(posedge clk) begin
    if (rst) begin
      n_entries <= 9'd1;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      n_entries <= pwdata[8:0];
    end
  end

  assign n0     = (n_entries == 9'd0) ? 9'd1 : n_entries;
  assign n_used = (int'(n0) > DEPTH) ? 9'(DEPTH) : n0;
  assign n_ext  = CW'(n_used);

  assign in_stall = (state != S_IDLE) || out_valid;
  assign accept   = in_valid && !in_stall;
  assign we       = accept && kind_t'(kind) == K_WRITE && {1'b0, index} < n_used;
  assign raddr    = (state == S_KADDR) ? oi[AW-1:0] : cnt[AW-1:0];
  assign rd_s     = $signed(rdata);
  assign c_fin    = c + 9'((pend && rd_s == key) ? 1 : 0);

  assign rem_s = {rem[8:0], dq[43]};
  assign qbit  = rem_s >= {1'b0, n_used};
  assign mag   = total[39] ? 40'(-total) : 40'(total);
  assign q_fin = {dq[42:0], qbit};
  assign q_sgn = neg ? 44'(-q_fin) : q_fin;

  dss_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(index)),
    .wdata (value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            kind_r      <= kind_t'(kind);
            max_value   <= '0;
            max_count   <= '0;
            min_value   <= '0;
            min_count   <= '0;
            value_range <= '0;
            total       <= '0;
            mean_q4     <= '0;
            mode_value  <= '0;
            mode_count  <= '0;
            match_count <= '0;
            bad_index   <= (kind_t'(kind) == K_WRITE) && !({1'b0, index} < n_used);
            cnt         <= '0;
            c           <= '0;
            pend        <= 1'b0;
            first       <= 1'b1;
            key         <= value;
            unique case (kind_t'(kind))
              K_WRITE: out_valid <= 1'b1;
              K_COUNT: state <= S_CNT;
              K_SUM:   state <= S_SCAN;
              K_NONE:  out_valid <= 1'b1;
            endcase
          end
        end
        S_SCAN: begin
          if (cnt < n_ext) begin
            cnt  <= cnt + 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            first <= 1'b0;
            total <= total + 40'(rd_s);
            if (first || rd_s > max_value) begin
              max_value <= rd_s;
            end
            if (first || rd_s < min_value) begin
              min_value <= rd_s;
            end
            if (cnt == n_ext) begin
              oi    <= '0;
              state <= S_KADDR;
            end
          end
        end
        S_KADDR: state <= S_KLOAD;
        S_KLOAD: begin
          key   <= rd_s;
          cnt   <= '0;
          c     <= '0;
          pend  <= 1'b0;
          state <= S_CNT;
        end
        S_CNT: begin
          if (cnt < n_ext) begin
            cnt  <= cnt + 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          c <= c_fin;
          if (pend && cnt == n_ext) begin
            if (kind_r == K_SUM) begin
              if (c_fin > mode_count) begin
                mode_count <= c_fin;
                mode_value <= key;
              end
              if (key == max_value) begin
                max_count <= c_fin;
              end
              if (key == min_value) begin
                min_count <= c_fin;
              end
              if (oi + 1'b1 == n_ext) begin
                neg   <= total[39];
                dq    <= {mag, 4'b0};
                rem   <= '0;
                dcnt  <= '0;
                state <= S_DIV;
              end else begin
                oi    <= oi + 1'b1;
                state <= S_KADDR;
              end
            end else begin
              match_count <= c_fin;
              out_valid   <= 1'b1;
              state       <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          rem  <= qbit ? rem_s - {1'b0, n_used} : rem_s;
          dq   <= q_fin;
          dcnt <= dcnt + 1'b1;
          if (dcnt == 6'(DivSteps - 1)) begin
            mean_q4     <= q_sgn[35:0];
            value_range <= 32'(max_value - min_value);
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_div_no_out: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> !out_valid) else $error("result shown during divide");
  a_mode_ge: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && kind_r == K_SUM |->
      mode_count >= max_count && mode_count >= min_count)
    else $error("mode count below max or min count");
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && kind_r == K_SUM |-> min_value <= max_value)
    else $error("minimum above maximum");

endmodule

FILE: src/dss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: dv/testbench.sv
// Testbench for the data set statistics block: directed and random words, checked against a predictor.
`timescale 1ns / 1ps
module testbench;
  import dss_pkg::*;

  localparam int DEPTH = 256;
  localparam int ADDR_N_ENTRIES = 0;

  typedef struct packed {
    logic signed [31:0] max_value;
    logic [8:0]         max_count;
    logic signed [31:0] min_value;
    logic [8:0]         min_count;
    logic [31:0]        value_range;
    logic signed [39:0] total;
    logic signed [35:0] mean_q4;
    logic signed [31:0] mode_value;
    logic [8:0]         mode_count;
    logic [8:0]         match_count;
    logic               bad_index;
  } stats_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] kind = K_WRITE;
  logic [7:0] index = 0;
  logic signed [31:0] value = 0;
  logic out_valid;
  logic out_stall = 0;
  stats_t got;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  data_set_statistics_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .index(index), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .max_value(got.max_value), .max_count(got.max_count),
    .min_value(got.min_value), .min_count(got.min_count),
    .value_range(got.value_range), .total(got.total), .mean_q4(got.mean_q4),
    .mode_value(got.mode_value), .mode_count(got.mode_count),
    .match_count(got.match_count), .bad_index(got.bad_index),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("DONE: errors detected");
    $finish;
  end

  logic signed [31:0] store_model [DEPTH];
  int n_used = 1;
  stats_t expected_stats [$];
  int errors = 0;
  int idle_pct = 24;
  bit hold_out = 0;

  function automatic int count_of(logic signed [31:0] v);
    int c = 0;
    for (int i = 0; i < n_used; i++) if (store_model[i] == v) c++;
    return c;
  endfunction

  function automatic stats_t predict_stats(kind_t k, logic [7:0] idx, logic signed [31:0] v);
    stats_t r;
    logic signed [31:0] mx, mn, md;
    logic signed [63:0] sum, mean;
    int mc, c;
    r = '0;
    case (k)
      K_WRITE: begin
        if (idx >= n_used) r.bad_index = 1'b1;
        else begin
          store_model[idx] = v;
        end
      end
      K_COUNT: r.match_count = 9'(count_of(v));
      K_SUM: begin
        mx = store_model[0];
        mn = store_model[0];
        md = store_model[0];
        sum = 0;
        mc = 0;
        for (int i = 0; i < n_used; i++) begin
          if (store_model[i] > mx) mx = store_model[i];
          if (store_model[i] < mn) mn = store_model[i];
          sum += store_model[i];
        end
        for (int i = 0; i < n_used; i++) begin
          c = count_of(store_model[i]);
          if (c > mc) begin
            mc = c;
            md = store_model[i];
          end
        end
        mean = (sum * 16) / n_used;
        r.max_value = mx;
        r.max_count = 9'(count_of(mx));
        r.min_value = mn;
        r.min_count = 9'(count_of(mn));
        r.value_range = mx - mn;
        r.total = sum[39:0];
        r.mean_q4 = mean[35:0];
        r.mode_value = md;
        r.mode_count = 9'(mc);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Result checker and receiver stall.
  always @(posedge clk) begin
    stats_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        e = expected_stats.pop_front();
        if (e.max_value !== got.max_value)
          $display("%0t: max_value exp %0d got %0d", $time, e.max_value, got.max_value);
        if (e.max_count !== got.max_count)
          $display("%0t: max_count exp %0d got %0d", $time, e.max_count, got.max_count);
        if (e.min_value !== got.min_value)
          $display("%0t: min_value exp %0d got %0d", $time, e.min_value, got.min_value);
        if (e.min_count !== got.min_count)
          $display("%0t: min_count exp %0d got %0d", $time, e.min_count, got.min_count);
        if (e.value_range !== got.value_range)
          $display("%0t: value_range exp %0d got %0d", $time, e.value_range, got.value_range);
        if (e.total !== got.total)
          $display("%0t: total exp %0d got %0d", $time, e.total, got.total);
        if (e.mean_q4 !== got.mean_q4)
          $display("%0t: mean_q4 exp %0d got %0d", $time, e.mean_q4, got.mean_q4);
        if (e.mode_value !== got.mode_value)
          $display("%0t: mode_value exp %0d got %0d", $time, e.mode_value, got.mode_value);
        if (e.mode_count !== got.mode_count)
          $display("%0t: mode_count exp %0d got %0d", $time, e.mode_count, got.mode_count);
        if (e.match_count !== got.match_count)
          $display("%0t: match_count exp %0d got %0d", $time, e.match_count, got.match_count);
        if (e.bad_index !== got.bad_index)
          $display("%0t: bad_index exp %0d got %0d", $time, e.bad_index, got.bad_index);
        if (e !== got) errors++;
      end
    end
    out_stall <= hold_out || ($urandom_range(99) < idle_pct);
  end

  task automatic send_word(kind_t k, logic [7:0] idx, logic signed [31:0] v);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    expected_stats.push_back(predict_stats(k, idx, v));
    kind <= k;
    index <= idx;
    value <= v;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_n_entries(int n);
    wait_drained();
    paddr <= 3'(ADDR_N_ENTRIES * 4);
    pwdata <= n;
    pwrite <= 1;
    psel <= 1;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    n_used = (n == 0) ? 1 : (n > DEPTH ? DEPTH : n);
  endtask

  function automatic logic signed [31:0] rand_value(int pool);
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(pool);
      2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return -$signed({1'b0, 31'($urandom_range(pool))});
    endcase
  endfunction

  task automatic fill_store();
    for (int i = 0; i < n_used; i++) send_word(K_WRITE, 8'(i), rand_value(3));
  endtask

  task automatic test_directed();
    write_n_entries(4);
    send_word(K_WRITE, 0, 32'sh7fffffff);
    send_word(K_WRITE, 1, 32'sh80000000);
    send_word(K_WRITE, 2, 32'sh80000000);
    send_word(K_WRITE, 3, 32'sh7fffffff);
    send_word(K_WRITE, 4, 5);
    send_word(K_WRITE, 8'hff, -1);
    send_word(K_SUM, 8'hff, -1);
    send_word(K_COUNT, 0, 32'sh80000000);
    send_word(K_COUNT, 0, 0);
    send_word(K_NONE, 8'hff, -1);
    send_word(K_WRITE, 2, -7);
    send_word(K_SUM, 0, 0);
    write_n_entries(0);
    send_word(K_WRITE, 1, 3);
    send_word(K_SUM, 0, 0);
    write_n_entries(256);
    for (int i = 0; i < 256; i++) send_word(K_WRITE, 8'(i), -1);
    send_word(K_SUM, 0, 0);
    send_word(K_COUNT, 0, -1);
    write_n_entries(511);
    send_word(K_SUM, 0, 0);
  endtask

  task automatic test_random(int words);
    int sent = 0;
    int ns;
    while (sent < words) begin
      ns = ($urandom_range(9) == 0) ? $urandom_range(256, 128) : $urandom_range(12, 1);
      write_n_entries(ns);
      fill_store();
      sent += n_used;
      repeat ($urandom_range(8, 2)) begin
        case ($urandom_range(4))
          0, 1: send_word(K_WRITE, 8'($urandom), rand_value(3));
          2: send_word(K_COUNT, 8'($urandom),
                       $urandom_range(1) ? store_model[$urandom_range(n_used - 1)]
                                         : rand_value(3));
          3: if (n_used <= 32) send_word(K_SUM, 8'($urandom), $urandom);
          default: send_word(K_NONE, 8'($urandom), $urandom);
        endcase
        sent++;
      end
      send_word(K_SUM, 8'($urandom), $urandom);
      sent++;
    end
  endtask

  task automatic test_backpressure();
    write_n_entries(6);
    idle_pct = 0;
    hold_out = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_out = 0;
      end
      for (int i = 0; i < 12; i++) send_word(K_WRITE, 8'($urandom_range(7)), $urandom);
    join
    wait_drained();
    send_word(K_SUM, 0, 0);
    idle_pct = 24;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    idle_pct = 0;
    test_random(40);
    idle_pct = 24;
    test_random(70);
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_stats.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

FILE: filelist.f
src/dss_pkg.sv
src/dss_ram.sv
src/data_set_statistics_core.sv
dv/testbench.sv
